[sv/lmls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lmls_pkg;

    localparam int CYCLE_W = 13;
    localparam int ADD_W   = 8;
    localparam int LINE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_WAIT      = 3'd0,
        EV_FRAME_END = 3'd1,
        EV_TO_OAM    = 3'd2,
        EV_TO_VB_XFR = 3'd3,
        EV_TO_HBLANK = 3'd4
    } lcd_event_t;

    localparam logic [CFG_IDX_W-1:0] REG_VBLANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OAM      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER = 2'd3;

    localparam logic [CYCLE_W-1:0] VBLANK_RESET   = 13'd4560;
    localparam logic [CYCLE_W-1:0] HBLANK_RESET   = 13'd201;
    localparam logic [CYCLE_W-1:0] OAM_RESET      = 13'd77;
    localparam logic [CYCLE_W-1:0] TRANSFER_RESET = 13'd169;

    localparam logic [LINE_W-1:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
    localparam int VBLANK_LINE_SPAN = 9;

endpackage

`default_nettype wire

[sv/lcd_mode_line_sequencer.sv]
// lcd mode and scan-line sequencer
// input channel: in_valid / in_stall carries cycles_advanced and
// vblank_irq_enabled; each transfer adds the cycle count to the elapsed
// counter of the current mode and produces exactly one result
// output channel: out_valid / out_stall carries lcd_mode, line_number,
// event_code, vblank_request and vblank_taken after the step
// result: registered, valid in the cycle after the input transfer
// throughput: one item per clock unless stalled; each step has one add,
// one compare against the mode duration, eight parallel constant-multiple
// compares for the vblank line, between the state and the output register
// configuration: cfg_write, cfg_index, cfg_data set four mode durations;
// the user is to write them only while no item is in flight; unenforced
// reset: mode hblank, line 0, elapsed 0, durations 4560 / 201 / 77 / 169,
// output register empty
// stall: while a result waits under out_stall, in_stall is raised and the
// result holds; as soon as the result is taken a new item is taken the
// same cycle
`timescale 1ns / 1ps
`default_nettype none

module lcd_mode_line_sequencer
    import lmls_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CYCLE_W-1:0]   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ADD_W-1:0]     cycles_advanced,
    input  wire logic                 vblank_irq_enabled,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                lcd_mode,
    output logic [LINE_W-1:0]         line_number,
    output logic [EVENT_W-1:0]        event_code,
    output logic                      vblank_request,
    output logic                      vblank_taken
);

    logic [CYCLE_W-1:0] vblank_cycles_reg;
    logic [CYCLE_W-1:0] hblank_cycles_reg;
    logic [CYCLE_W-1:0] oam_cycles_reg;
    logic [CYCLE_W-1:0] transfer_cycles_reg;

    lcd_mode_t          mode_reg;
    lcd_mode_t          mode_next;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  line_next;
    logic [CYCLE_W-1:0] elapsed_reg;
    logic [CYCLE_W-1:0] elapsed_next;

    logic               out_valid_reg;
    lcd_mode_t          out_mode_reg;
    logic [LINE_W-1:0]  out_line_reg;
    lcd_event_t         out_event_reg;
    lcd_event_t         event_next;
    logic               out_req_reg;
    logic               req_next;
    logic               out_taken_reg;
    logic               taken_next;

    logic               in_xfer;
    logic [CYCLE_W:0]   sum;
    logic [CYCLE_W-1:0] duration;
    logic               done;
    logic [CYCLE_W+3:0] sum_x9;
    logic [3:0]         vb_step;
    logic [LINE_W-1:0]  vb_line;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        case (mode_reg)
            MODE_HBLANK: duration = hblank_cycles_reg;
            MODE_VBLANK: duration = vblank_cycles_reg;
            MODE_OAM:    duration = oam_cycles_reg;
            default:     duration = transfer_cycles_reg;
        endcase
    end

    assign sum  = {1'b0, elapsed_reg} + {{(CYCLE_W+1-ADD_W){1'b0}}, cycles_advanced};
    assign done = sum >= {1'b0, duration};

    // vblank line: count multiples of the duration below 9 * elapsed
    assign sum_x9 = {1'b0, sum[CYCLE_W-1:0], 3'b000} + {4'b0000, sum[CYCLE_W-1:0]};

    always_comb
    begin
        vb_step = 4'd0;
        for (int k = 1; k < VBLANK_LINE_SPAN; k++)
        begin
            if (sum_x9 >= ({4'b0000, vblank_cycles_reg} * (CYCLE_W+4)'(k)))
            begin
                vb_step = vb_step + 4'd1;
            end
        end
    end

    assign vb_line = FIRST_VBLANK_LINE + {4'b0000, vb_step};

    // next state
    always_comb
    begin
        mode_next    = mode_reg;
        line_next    = line_reg;
        elapsed_next = sum[CYCLE_W-1:0];
        if (done)
        begin
            elapsed_next = '0;
            case (mode_reg)
                MODE_HBLANK:
                begin
                    mode_next = (line_reg < LAST_VISIBLE_LINE) ? MODE_OAM : MODE_VBLANK;
                end
                MODE_OAM:
                begin
                    mode_next = MODE_TRANSFER;
                    line_next = line_reg + 8'd1;
                end
                MODE_TRANSFER:
                begin
                    mode_next = MODE_HBLANK;
                end
                default:
                begin
                    mode_next = MODE_OAM;
                    line_next = '0;
                end
            endcase
        end
        else if (mode_reg == MODE_VBLANK)
        begin
            line_next = vb_line;
        end
    end

    // step outputs
    always_comb
    begin
        event_next = EV_WAIT;
        req_next   = 1'b0;
        taken_next = 1'b0;
        if (done)
        begin
            case (mode_reg)
                MODE_HBLANK:
                begin
                    if (line_reg < LAST_VISIBLE_LINE)
                    begin
                        event_next = EV_TO_OAM;
                    end
                    else
                    begin
                        event_next = EV_TO_VB_XFR;
                        req_next   = 1'b1;
                    end
                end
                MODE_OAM:      event_next = EV_TO_VB_XFR;
                MODE_TRANSFER: event_next = EV_TO_HBLANK;
                default:
                begin
                    event_next = EV_FRAME_END;
                    taken_next = vblank_irq_enabled;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vblank_cycles_reg   <= VBLANK_RESET;
            hblank_cycles_reg   <= HBLANK_RESET;
            oam_cycles_reg      <= OAM_RESET;
            transfer_cycles_reg <= TRANSFER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VBLANK:   vblank_cycles_reg   <= cfg_data;
                REG_HBLANK:   hblank_cycles_reg   <= cfg_data;
                REG_OAM:      oam_cycles_reg      <= cfg_data;
                REG_TRANSFER: transfer_cycles_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HBLANK;
            line_reg      <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg      <= mode_next;
                line_reg      <= line_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_mode_reg  <= mode_next;
            out_line_reg  <= line_next;
            out_event_reg <= event_next;
            out_req_reg   <= req_next;
            out_taken_reg <= taken_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lcd_mode       = out_mode_reg;
    assign line_number    = out_line_reg;
    assign event_code     = out_event_reg;
    assign vblank_request = out_req_reg;
    assign vblank_taken   = out_taken_reg;

endmodule

`default_nettype wire

[sv/lmls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmls_checker
    import lmls_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_write,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [CYCLE_W-1:0]   cfg_data,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic [ADD_W-1:0]     cycles_advanced,
    input wire logic                 vblank_irq_enabled,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [1:0]           lcd_mode,
    input wire logic [LINE_W-1:0]    line_number,
    input wire logic [EVENT_W-1:0]   event_code,
    input wire logic                 vblank_request,
    input wire logic                 vblank_taken
);

    // entering vblank is the only step that raises the request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_request |->
            lcd_mode == MODE_VBLANK && event_code == EV_TO_VB_XFR)
        else $error("vblank request outside vblank entry");

    // a taken interrupt only comes with the frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_taken |-> event_code == EV_FRAME_END)
        else $error("vblank taken without frame end");

    // frame end restarts at line 0 in oam search
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_FRAME_END |->
            lcd_mode == MODE_OAM && line_number == '0)
        else $error("frame end with wrong mode or line");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(lcd_mode) && $stable(line_number) &&
            $stable(event_code))
        else $error("stalled result changed");

endmodule

bind lcd_mode_line_sequencer lmls_checker u_lmls_checker (.*);

`default_nettype wire
